// ----- rtl/packed_normal_decoder_top_assert.svh -----
// Assertion macros shared by the packed normal decoder RTL.
`ifndef PACKED_NORMAL_DECODER_TOP_ASSERT_SVH
`define PACKED_NORMAL_DECODER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Property checked on every rising clock edge outside reset
`define PND_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition that must never hold outside reset
`define PND_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define PND_ASSERT(lbl, prop, msg)
`define PND_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- rtl/pnd_pkg.sv -----
// Package of the packed normal decoder: widths, constants and cell payload types.
package pnd_pkg;

  // Output scale is 2^FRAC_BITS
  localparam int FRAC_BITS = 14;

  // Remainder widths: X/Y lanes divide by DEN, the Z lane by DEN^2
  localparam int RW  = 19;
  localparam int ZRW = 37;
  localparam logic [RW:0]  DEN_X = 20'd327674;
  localparam logic [ZRW:0] DEN_Z = 38'd107370250276;

  // Front end constants
  localparam logic signed [21:0] DEN_A  = 22'sd327674;
  localparam logic [19:0]        DEN1_M = 20'd327674;
  localparam logic [19:0]        DEN2_M = 20'd655348;
  localparam logic [19:0]        DEN3_M = 20'd983022;
  localparam logic [18:0]        DEN_B  = 19'd327674;
  localparam logic signed [41:0] DEN_SQ = 42'sd107370250276;

  // Quotient and root widths
  localparam int XQW = FRAC_BITS + 3;      // 2 integer bits + FRAC_BITS+1 fraction bits
  localparam int YQW = FRAC_BITS + 2;      // 1 integer bit + FRAC_BITS+1 fraction bits
  localparam int ZQW = 2 * FRAC_BITS + 2;  // fraction bits of radicand / DEN^2
  localparam int SW  = FRAC_BITS + 1;      // root result
  localparam int SRW = FRAC_BITS + 2;      // root remainder
  localparam int SCW = FRAC_BITS + 4;      // root compare width

  // Chain lengths and latency in cycles from accept edge to result edge
  localparam int XY_STEPS   = FRAC_BITS + 1;
  localparam int DIV_CELLS  = ZQW;
  localparam int SQRT_CELLS = FRAC_BITS + 1;
  localparam int LATENCY    = DIV_CELLS + SQRT_CELLS + 4;

  // Saturation of the output magnitudes
  localparam int MW = (XQW > 17) ? XQW : 17;
  localparam logic [MW-1:0] X_POS_LIM = MW'(65535);
  localparam logic [MW-1:0] X_NEG_LIM = MW'(65536);
  localparam logic [MW-1:0] Y_POS_LIM = MW'(32767);
  localparam logic [MW-1:0] Y_NEG_LIM = MW'(32768);
  localparam logic [MW-1:0] Z_LIM     = MW'(32767);
  localparam int X_UNIT_LIM = (FRAC_BITS >= 16) ? 65535 : (1 << FRAC_BITS);

  // Payload of a long-division cell
  typedef struct packed {
    logic           last;
    logic           x_neg;
    logic           y_neg;
    logic           z_neg;
    logic [RW-1:0]  x_rem;
    logic [RW-1:0]  y_rem;
    logic [XQW-1:0] x_quo;
    logic [YQW-1:0] y_quo;
    logic [ZRW-1:0] z_rem;
    logic [ZQW-1:0] z_quo;
  } div_cell_t;

  // Payload of a square-root cell
  typedef struct packed {
    logic           last;
    logic           x_neg;
    logic           y_neg;
    logic           z_neg;
    logic [XQW-1:0] x_quo;
    logic [YQW-1:0] y_quo;
    logic [ZQW-1:0] z_quo;
    logic [SRW-1:0] s_rem;
    logic [SW-1:0]  s_res;
  } sq_cell_t;

endpackage

// ----- rtl/pnd_div_cell.sv -----
// One restoring long-division step for the X, Y and Z lanes of the decoder chain.
module pnd_div_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                xy_en_i,
  input  logic                valid_i,
  input  pnd_pkg::div_cell_t  data_i,
  output logic                valid_o,
  output pnd_pkg::div_cell_t  data_o
);

  logic [pnd_pkg::RW:0]  x_tr, x_df, y_tr, y_df;
  logic [pnd_pkg::ZRW:0] z_tr, z_df;
  logic                  x_ge, y_ge, z_ge;
  logic                  valid_q;
  pnd_pkg::div_cell_t    data_d, data_q;

  // Trial subtract of the doubled remainder, one quotient bit per lane
  always_comb begin
    x_tr = {data_i.x_rem, 1'b0};
    x_df = x_tr - pnd_pkg::DEN_X;
    x_ge = (x_tr >= pnd_pkg::DEN_X);
    y_tr = {data_i.y_rem, 1'b0};
    y_df = y_tr - pnd_pkg::DEN_X;
    y_ge = (y_tr >= pnd_pkg::DEN_X);
    z_tr = {data_i.z_rem, 1'b0};
    z_df = z_tr - pnd_pkg::DEN_Z;
    z_ge = (z_tr >= pnd_pkg::DEN_Z);

    data_d = data_i;
    // X and Y need fewer fraction bits; past that they just ride along
    if (xy_en_i) begin
      data_d.x_rem = x_ge ? x_df[pnd_pkg::RW-1:0] : x_tr[pnd_pkg::RW-1:0];
      data_d.x_quo = {data_i.x_quo[pnd_pkg::XQW-2:0], x_ge};
      data_d.y_rem = y_ge ? y_df[pnd_pkg::RW-1:0] : y_tr[pnd_pkg::RW-1:0];
      data_d.y_quo = {data_i.y_quo[pnd_pkg::YQW-2:0], y_ge};
    end
    data_d.z_rem = z_ge ? z_df[pnd_pkg::ZRW-1:0] : z_tr[pnd_pkg::ZRW-1:0];
    data_d.z_quo = {data_i.z_quo[pnd_pkg::ZQW-2:0], z_ge};
  end

  // Item valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/pnd_sqrt_cell.sv -----
// One digit of the restoring square root of the Z quotient, two radicand bits per cell.
module pnd_sqrt_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  pnd_pkg::sq_cell_t  data_i,
  output logic               valid_o,
  output pnd_pkg::sq_cell_t  data_o
);

  logic [pnd_pkg::SCW-1:0] rem_w, trial, diff;
  logic                    ge;
  logic                    valid_q;
  pnd_pkg::sq_cell_t       data_d, data_q;

  // Bring down the next bit pair and try root bit one
  always_comb begin
    rem_w = {data_i.s_rem, data_i.z_quo[pnd_pkg::ZQW-1 -: 2]};
    trial = {1'b0, data_i.s_res, 2'b01};
    diff  = rem_w - trial;
    ge    = (rem_w >= trial);

    data_d       = data_i;
    data_d.s_rem = ge ? diff[pnd_pkg::SRW-1:0] : rem_w[pnd_pkg::SRW-1:0];
    data_d.s_res = {data_i.s_res[pnd_pkg::SW-2:0], ge};
    data_d.z_quo = {data_i.z_quo[pnd_pkg::ZQW-3:0], 2'b00};
  end

  // Item valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/packed_normal_decoder_top.sv -----
// Packed vertex normal decoder: front end, division and root cell chains, output stage.
//
// Usage: drive packed_x_i, packed_y_i and last_in_i with start_i high; the item
// is taken at any rising edge where start_i is high and busy_o is low. After
// reset busy_o is high for one cycle, then stays low: a new item may enter on
// every clock, so the sustained rate is one item per cycle.
// Each item's result shows on norm_x_o, norm_y_o, norm_z_o and last_out_o for
// exactly one cycle with done_o high. Between the accepting edge and that
// result lie three front end stages (offset, squares, radicand), 2*FRAC_BITS+2
// division cells (one quotient bit each), FRAC_BITS+1 root cells (one root bit
// each) and the output register. Results leave in the order items came in.
// The receiver cannot stall, so no result is ever held back.
// Reset clears every valid bit in the chain; items in flight are dropped.
`include "packed_normal_decoder_top_assert.svh"

module packed_normal_decoder_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [15:0]        packed_x_i,
  input  logic [15:0]        packed_y_i,
  input  logic               last_in_i,
  output logic               busy_o,
  output logic               done_o,
  output logic signed [16:0] norm_x_o,
  output logic signed [15:0] norm_y_o,
  output logic signed [15:0] norm_z_o,
  output logic               last_out_o
);

  logic busy_q;
  logic accept;

  // Stage 1 signals
  logic [20:0]        x20;
  logic [19:0]        y20;
  logic signed [21:0] a_s, b_s;
  logic [19:0]        amag_d, amag_q;
  logic [18:0]        bmag_d, bmag_q;
  logic               f1_v_q, a_neg_q, b_neg_q, zs1_q, last1_q;

  // Stage 2 signals
  logic [39:0] a2_d, a2_q;
  logic [37:0] b2_d, b2_q;
  logic [19:0] ac, xr;
  logic [1:0]  xqi_d, xqi_q;
  logic [18:0] xr_q, yr_d, yr_q;
  logic        yqi_d, yqi_q;
  logic        f2_v_q, a_neg2_q, b_neg2_q, zs2_q, last2_q;

  // Stage 3 signals
  logic signed [41:0] rad;
  pnd_pkg::div_cell_t f3_d, f3_q;
  logic               f3_v_q;

  // Cell chains
  logic [pnd_pkg::DIV_CELLS:0]  div_v;
  pnd_pkg::div_cell_t           div_d [pnd_pkg::DIV_CELLS+1];
  logic [pnd_pkg::SQRT_CELLS:0] sq_v;
  pnd_pkg::sq_cell_t            sq_d [pnd_pkg::SQRT_CELLS+1];

  // Output stage signals
  pnd_pkg::sq_cell_t             fin;
  logic [pnd_pkg::XQW:0]         xs;
  logic [pnd_pkg::YQW:0]         ys;
  logic [pnd_pkg::SW:0]          zs;
  logic [pnd_pkg::MW-1:0]        xm, ym, zm, xl, yl, zl, xv, yv, zv;
  logic                          done_q, last_q;
  logic signed [16:0]            norm_x_q;
  logic signed [15:0]            norm_y_q, norm_z_q;

  // Busy only in the first cycle after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign accept = start_i && !busy_q;

  // Stage 1: a = 20*m - DEN, split into magnitude and sign
  always_comb begin
    x20    = {1'b0, packed_x_i, 4'b0000} + {3'b000, packed_x_i, 2'b00};
    y20    = {1'b0, packed_y_i[14:0], 4'b0000} + {3'b000, packed_y_i[14:0], 2'b00};
    a_s    = $signed({1'b0, x20}) - pnd_pkg::DEN_A;
    b_s    = $signed({2'b00, y20}) - pnd_pkg::DEN_A;
    amag_d = a_s[21] ? 20'(-a_s) : a_s[19:0];
    bmag_d = b_s[21] ? 19'(-b_s) : b_s[18:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
      f3_v_q <= 1'b0;
    end else begin
      f1_v_q <= accept;
      f2_v_q <= f1_v_q;
      f3_v_q <= f2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    amag_q  <= amag_d;
    bmag_q  <= bmag_d;
    a_neg_q <= a_s[21];
    b_neg_q <= b_s[21];
    zs1_q   <= packed_y_i[15];
    last1_q <= last_in_i;
  end

  // Stage 2: squares, integer quotient digits of X and Y
  always_comb begin
    a2_d = 40'(amag_q) * 40'(amag_q);
    b2_d = 38'(bmag_q) * 38'(bmag_q);
    // X beyond three saturates anyway
    ac = (amag_q > pnd_pkg::DEN3_M) ? pnd_pkg::DEN3_M : amag_q;
    if (ac >= pnd_pkg::DEN3_M) begin
      xqi_d = 2'd3;
      xr    = ac - pnd_pkg::DEN3_M;
    end else if (ac >= pnd_pkg::DEN2_M) begin
      xqi_d = 2'd2;
      xr    = ac - pnd_pkg::DEN2_M;
    end else if (ac >= pnd_pkg::DEN1_M) begin
      xqi_d = 2'd1;
      xr    = ac - pnd_pkg::DEN1_M;
    end else begin
      xqi_d = 2'd0;
      xr    = ac;
    end
    yqi_d = (bmag_q >= pnd_pkg::DEN_B);
    yr_d  = yqi_d ? (bmag_q - pnd_pkg::DEN_B) : bmag_q;
  end

  always_ff @(posedge clk_i) begin
    a2_q     <= a2_d;
    b2_q     <= b2_d;
    xqi_q    <= xqi_d;
    xr_q     <= xr[18:0];
    yqi_q    <= yqi_d;
    yr_q     <= yr_d;
    a_neg2_q <= a_neg_q;
    b_neg2_q <= b_neg_q;
    zs2_q    <= zs1_q;
    last2_q  <= last1_q;
  end

  // Stage 3: radicand DEN^2 - a^2 - b^2, zero when negative.
  // a and b are never zero, so the radicand stays below DEN^2.
  always_comb begin
    rad        = pnd_pkg::DEN_SQ - $signed({2'b00, a2_q}) - $signed({4'b0000, b2_q});
    f3_d.last  = last2_q;
    f3_d.x_neg = a_neg2_q;
    f3_d.y_neg = b_neg2_q;
    f3_d.z_neg = zs2_q;
    f3_d.x_rem = xr_q;
    f3_d.y_rem = yr_q;
    f3_d.x_quo = pnd_pkg::XQW'(xqi_q);
    f3_d.y_quo = pnd_pkg::YQW'(yqi_q);
    f3_d.z_rem = rad[41] ? '0 : rad[pnd_pkg::ZRW-1:0];
    f3_d.z_quo = '0;
  end

  always_ff @(posedge clk_i) begin
    f3_q <= f3_d;
  end

  assign div_v[0] = f3_v_q;
  assign div_d[0] = f3_q;

  // Division chain: one quotient bit per cell
  for (genvar k = 0; k < pnd_pkg::DIV_CELLS; k++) begin : g_div
    pnd_div_cell u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .xy_en_i (k < pnd_pkg::XY_STEPS),
      .valid_i (div_v[k]),
      .data_i  (div_d[k]),
      .valid_o (div_v[k+1]),
      .data_o  (div_d[k+1])
    );
  end

  // Root chain starts from an empty remainder
  always_comb begin
    sq_d[0].last  = div_d[pnd_pkg::DIV_CELLS].last;
    sq_d[0].x_neg = div_d[pnd_pkg::DIV_CELLS].x_neg;
    sq_d[0].y_neg = div_d[pnd_pkg::DIV_CELLS].y_neg;
    sq_d[0].z_neg = div_d[pnd_pkg::DIV_CELLS].z_neg;
    sq_d[0].x_quo = div_d[pnd_pkg::DIV_CELLS].x_quo;
    sq_d[0].y_quo = div_d[pnd_pkg::DIV_CELLS].y_quo;
    sq_d[0].z_quo = div_d[pnd_pkg::DIV_CELLS].z_quo;
    sq_d[0].s_rem = '0;
    sq_d[0].s_res = '0;
  end

  assign sq_v[0] = div_v[pnd_pkg::DIV_CELLS];

  for (genvar j = 0; j < pnd_pkg::SQRT_CELLS; j++) begin : g_sqrt
    pnd_sqrt_cell u_sqrt (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_v[j]),
      .data_i  (sq_d[j]),
      .valid_o (sq_v[j+1]),
      .data_o  (sq_d[j+1])
    );
  end

  assign fin = sq_d[pnd_pkg::SQRT_CELLS];

  // Output stage: round half up on the doubled quotients, saturate, apply sign
  always_comb begin
    xs = {1'b0, fin.x_quo} + (pnd_pkg::XQW+1)'(1);
    ys = {1'b0, fin.y_quo} + (pnd_pkg::YQW+1)'(1);
    zs = {1'b0, fin.s_res} + (pnd_pkg::SW+1)'(1);
    xm = pnd_pkg::MW'(xs[pnd_pkg::XQW:1]);
    ym = pnd_pkg::MW'(ys[pnd_pkg::YQW:1]);
    zm = pnd_pkg::MW'(zs[pnd_pkg::SW:1]);
    if (fin.x_neg) begin
      xl = (xm > pnd_pkg::X_NEG_LIM) ? pnd_pkg::X_NEG_LIM : xm;
    end else begin
      xl = (xm > pnd_pkg::X_POS_LIM) ? pnd_pkg::X_POS_LIM : xm;
    end
    if (fin.y_neg) begin
      yl = (ym > pnd_pkg::Y_NEG_LIM) ? pnd_pkg::Y_NEG_LIM : ym;
    end else begin
      yl = (ym > pnd_pkg::Y_POS_LIM) ? pnd_pkg::Y_POS_LIM : ym;
    end
    zl = (zm > pnd_pkg::Z_LIM) ? pnd_pkg::Z_LIM : zm;
    xv = fin.x_neg ? -xl : xl;
    yv = fin.y_neg ? -yl : yl;
    // zero magnitude stays zero under negation
    zv = fin.z_neg ? -zl : zl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= sq_v[pnd_pkg::SQRT_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    norm_x_q <= $signed(xv[16:0]);
    norm_y_q <= $signed(yv[15:0]);
    norm_z_q <= $signed(zv[15:0]);
    last_q   <= fin.last;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign norm_x_o   = norm_x_q;
  assign norm_y_o   = norm_y_q;
  assign norm_z_o   = norm_z_q;
  assign last_out_o = last_q;

  // Every accepted item comes out after the fixed latency, and only those
  `PND_ASSERT(a_done_follows, ((start_i && !busy_o) |-> ##(pnd_pkg::LATENCY) done_o), "item lost in the cell chain")
  `PND_ASSERT(a_done_cause, (done_o |-> $past(start_i && !busy_o, pnd_pkg::LATENCY)), "result without an accepted item")
  // Side band stays aligned with its item
  `PND_ASSERT(a_last_kept, (done_o |-> (last_out_o == $past(last_in_i, pnd_pkg::LATENCY))), "last flag out of step")
  // A nonzero Z needs x^2 + y^2 below one
  `PND_ASSERT(a_z_needs_unit_x, ((done_o && (norm_z_o != 16'sd0)) |-> (int'(norm_x_o) <= pnd_pkg::X_UNIT_LIM)), "nonzero Z with X above one")
  `PND_ASSERT_NEVER(a_busy_once, (busy_o && $past(!busy_o)), "busy raised after reset release")

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the packed vertex normal decoder.
`timescale 1ns / 100ps

module tb_top;

  localparam longint      DEN         = 327674;
  localparam int          RAND_ITEMS  = 1830;
  localparam int unsigned CYCLE_LIMIT = 100000;

  // One decoded normal as it shows on the result ports
  typedef struct {
    logic signed [16:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               last;
  } normal_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic [15:0]        packed_x_i;
  logic [15:0]        packed_y_i;
  logic               last_in_i;
  logic               busy_o;
  logic               done_o;
  logic signed [16:0] norm_x_o;
  logic signed [15:0] norm_y_o;
  logic signed [15:0] norm_z_o;
  logic               last_out_o;

  normal_t     decoded_q[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  packed_normal_decoder_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .packed_x_i (packed_x_i),
    .packed_y_i (packed_y_i),
    .last_in_i  (last_in_i),
    .busy_o     (busy_o),
    .done_o     (done_o),
    .norm_x_o   (norm_x_o),
    .norm_y_o   (norm_y_o),
    .norm_z_o   (norm_z_o),
    .last_out_o (last_out_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // round(a * 2^F / DEN), ties away from zero
  function automatic longint round_scaled(longint a);
    longint unsigned mag;
    longint unsigned q;
    mag = (a < 0) ? -a : a;
    mag = mag << pnd_pkg::FRAC_BITS;
    q = (2 * mag + DEN) / (2 * DEN);
    return (a < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Integer square root, floor
  function automatic longint unsigned int_sqrt(longint unsigned t);
    longint unsigned root;
    longint unsigned b_v;
    root = 0;
    b_v = 64'd1 << 62;
    while (b_v > t) b_v >>= 2;
    while (b_v != 0) begin
      if (t >= root + b_v) begin
        t -= root + b_v;
        root = (root >> 1) + b_v;
      end else begin
        root >>= 1;
      end
      b_v >>= 2;
    end
    return root;
  endfunction

  // round(sqrt(n) * 2^F / DEN), ties upward; n <= DEN^2
  function automatic longint z_magnitude(longint unsigned n);
    longint unsigned d2;
    longint unsigned q;
    longint unsigned rem;
    int i;
    d2 = DEN * DEN;
    q = n / d2;
    rem = n % d2;
    for (i = 0; i < 2 * pnd_pkg::FRAC_BITS + 2; i++) begin
      rem <<= 1;
      q <<= 1;
      if (rem >= d2) begin
        rem -= d2;
        q |= 1;
      end
    end
    return longint'((int_sqrt(q) + 1) >> 1);
  endfunction

  // Expected decode of one packed normal
  function automatic normal_t decode_normal(logic [15:0] xw, logic [15:0] yw, logic lst);
    normal_t r;
    longint one;
    longint a;
    longint b;
    longint rad;
    longint nx;
    longint ny;
    longint nz;
    one = longint'(1) << pnd_pkg::FRAC_BITS;
    a = 20 * longint'(xw) - DEN;
    b = 20 * longint'(yw[14:0]) - DEN;
    rad = DEN * DEN - a * a - b * b;
    nx = clamp(clamp(round_scaled(a), -one, 3 * one), -65536, 65535);
    ny = clamp(clamp(round_scaled(b), -one, one), -32768, 32767);
    nz = 0;
    // Z only exists inside the unit circle; no negative zero
    if (rad > 0) begin
      nz = clamp(clamp(z_magnitude(rad), 0, one), 0, 32767);
      if (yw[15]) nz = -nz;
    end
    r.nx   = 17'(nx);
    r.ny   = 16'(ny);
    r.nz   = 16'(nz);
    r.last = lst;
    return r;
  endfunction

  // Result checker: every strobe is matched against the oldest decoded normal
  always @(posedge clk_i) begin
    normal_t want;
    if (rst_ni && done_o) begin
      if (decoded_q.size() == 0) begin
        $error("result with no item outstanding");
        error_count++;
      end else begin
        want = decoded_q.pop_front();
        if (norm_x_o !== want.nx) begin
          $error("norm_x: expected %0d, actual %0d", want.nx, norm_x_o);
          error_count++;
        end
        if (norm_y_o !== want.ny) begin
          $error("norm_y: expected %0d, actual %0d", want.ny, norm_y_o);
          error_count++;
        end
        if (norm_z_o !== want.nz) begin
          $error("norm_z: expected %0d, actual %0d", want.nz, norm_z_o);
          error_count++;
        end
        if (last_out_o !== want.last) begin
          $error("last_out: expected %0b, actual %0b", want.last, last_out_o);
          error_count++;
        end
      end
    end
  end

  // Present one item and hold it until the block takes it
  task automatic send_normal(logic [15:0] xw, logic [15:0] yw, logic lst);
    start_i    <= 1'b1;
    packed_x_i <= xw;
    packed_y_i <= yw;
    last_in_i  <= lst;
    do @(posedge clk_i); while (busy_o);
    decoded_q.insert(decoded_q.size(), decode_normal(xw, yw, lst));
  endtask

  task automatic idle_cycles(int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Hold off until every outstanding item has come back
  task automatic drain_results();
    start_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
  endtask

  // Corners of the raw words, back to back but for one idle gap
  task automatic test_field_extremes();
    send_normal(16'h0000, 16'h0000, 1'b0);
    send_normal(16'hFFFF, 16'hFFFF, 1'b1);
    send_normal(16'hFFFF, 16'h7FFF, 1'b0);
    send_normal(16'h0000, 16'h7FFF, 1'b1);
    send_normal(16'hFFFF, 16'h0000, 1'b0);
    idle_cycles(3);
    send_normal(16'h8000, 16'h8000, 1'b1);
    send_normal(16'hAAAA, 16'h5555, 1'b0);
    send_normal(16'h5555, 16'hAAAA, 1'b1);
    send_normal(16'h7FFF, 16'hC000, 1'b0);
    drain_results();
  endtask

  // Z rebuild: poles, sign handling, rim and outside the circle
  task automatic test_z_reconstruction();
    send_normal(16'd16384, 16'd16384, 1'b0);           // z = +1
    send_normal(16'd16384, 16'd16384 | 16'h8000, 1'b1); // z = -1
    send_normal(16'd16383, 16'd16383 | 16'h8000, 1'b0);
    idle_cycles(1);
    send_normal(16'd0, 16'h8000, 1'b1);                 // sign set, zero Z
    send_normal(16'd32767, 16'h7FFF, 1'b0);             // radicand negative
    send_normal(16'd0, 16'd16384 | 16'h8000, 1'b0);     // just outside the rim
    send_normal(16'd32767, 16'd16384 | 16'h8000, 1'b1); // just inside the rim
    send_normal(16'd32767, 16'd16384, 1'b0);
    send_normal(16'd40000, 16'd16384, 1'b1);            // X above one
    drain_results();
  endtask

  // Random packed normal, biased toward the unit circle and its rim
  task automatic random_normal(output logic [15:0] xw, output logic [15:0] yw);
    int      kind;
    longint  a;
    longint  b;
    longint  m;
    kind = $urandom_range(0, 9);
    if (kind < 5) begin
      xw = 16'($urandom_range(0, 32767));
      yw = 16'($urandom);
    end else if (kind < 7) begin
      xw = 16'($urandom_range(0, 32767));
      a = 20 * longint'(xw) - DEN;
      b = longint'(int_sqrt(DEN * DEN - a * a));
      if ($urandom_range(0, 1)) b = -b;
      m = clamp((b + DEN) / 20 + $urandom_range(0, 2) - 1, 0, 32767);
      yw = {1'($urandom), 15'(m)};
    end else begin
      xw = 16'($urandom);
      yw = 16'($urandom);
    end
  endtask

  // Random stream in bursts, with one full drain halfway
  task automatic test_random_stream();
    int          sent;
    int          burst;
    logic [15:0] xw;
    logic [15:0] yw;
    bit          drained;
    sent = 0;
    drained = 1'b0;
    while (sent < RAND_ITEMS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        if (sent < RAND_ITEMS) begin
          random_normal(xw, yw);
          send_normal(xw, yw, 1'($urandom));
          sent++;
        end
      end
      if (!drained && sent >= RAND_ITEMS / 2) begin
        drain_results();
        drained = 1'b1;
      end else if ($urandom_range(0, 4) != 0) begin
        idle_cycles($urandom_range(1, 10));
      end
    end
    drain_results();
  endtask

  // Test sequence
  initial begin
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    packed_x_i = '0;
    packed_y_i = '0;
    last_in_i  = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_z_reconstruction();
    test_random_stream();

    // Let any stray result show up
    repeat (pnd_pkg::LATENCY + 8) @(posedge clk_i);
    if (decoded_q.size() != 0) begin
      $error("%0d items never produced a result", decoded_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
